/* sv/dfsc_pkg.sv */
// ----------------------------------------------------------------------------
// dfsc_pkg
// Shared types and constants for the dual fan step-curve controller.
// ----------------------------------------------------------------------------
package dfsc_pkg;

    localparam int CURVE_POINTS_DEF = 8;
    localparam int REG_ADDR_W       = 6;
    localparam int CFG_DATA_W       = 64;

    localparam logic [7:0] HANDS_OFF  = 8'hFF;
    localparam logic [7:0] FAN_MAX    = 8'd100;
    localparam logic [7:0] HYST_RESET = 8'd5;

    typedef enum logic [2:0] {
        REG_HYST      = 3'd0,
        REG_CPU_COUNT = 3'd1,
        REG_GPU_COUNT = 3'd2,
        REG_CPU_LOW   = 3'd3,
        REG_CPU_HIGH  = 3'd4,
        REG_GPU_LOW   = 3'd5,
        REG_GPU_HIGH  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] target;
        logic [7:0] set_temp;
    } chan_res_t;

endpackage

/* sv/dfsc_chan.sv */
// ----------------------------------------------------------------------------
// dfsc_chan
// One channel: step-curve lookup followed by downward hysteresis.
// ----------------------------------------------------------------------------
module dfsc_chan #(
    parameter int POINTS = dfsc_pkg::CURVE_POINTS_DEF
) (
    input  logic                   sample_ok,
    input  logic [7:0]             temp,
    input  logic [16*POINTS-1:0]   curve,
    input  logic [3:0]             count,
    input  logic [7:0]             hyst_deg,
    input  logic [7:0]             fan_now,
    input  logic [7:0]             set_temp,
    output dfsc_pkg::chan_res_t    res
);
    import dfsc_pkg::*;

    localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;

    logic [3:0]    n;
    logic [IW-1:0] last;
    logic [IW-1:0] sel;
    logic [7:0]    fan_byte;
    logic [7:0]    raw;
    logic          active;
    logic [8:0]    thresh;

    assign n    = (count > 4'(POINTS)) ? 4'(POINTS) : count;
    assign last = IW'(n - 4'd1);

    always_comb
    begin
        sel = last;
        for (int i = POINTS - 2; i >= 0; i--)
        begin
            if ((IW'(i) < last) && (temp >= curve[16*i +: 8]) &&
                (temp < curve[16*(i+1) +: 8]))
            begin
                sel = IW'(i);
            end
        end
        if (temp >= curve[16*last +: 8])
        begin
            sel = last;
        end
        if (temp < curve[7:0])
        begin
            sel = '0;
        end
    end

    assign fan_byte = curve[16*sel + 8 +: 8];
    assign raw = (fan_byte == HANDS_OFF) ? HANDS_OFF :
                 (fan_byte > FAN_MAX)    ? FAN_MAX   : fan_byte;

    assign active = sample_ok && (temp != 8'd0) && (n != 4'd0);
    assign thresh = {1'b0, temp} + {1'b0, hyst_deg};

    always_comb
    begin
        res.target   = fan_now;
        res.set_temp = set_temp;
        if (active)
        begin
            if (raw == HANDS_OFF)
            begin
                res.target   = HANDS_OFF;
                res.set_temp = 8'd0;
            end
            else if ((fan_now == HANDS_OFF) || ($signed(raw) > $signed(fan_now)))
            begin
                res.target   = raw;
                res.set_temp = temp;
            end
            else if (($signed(raw) < $signed(fan_now)) && (thresh <= {1'b0, set_temp}))
            begin
                res.target   = raw;
                res.set_temp = temp;
            end
        end
    end

endmodule

/* sv/dual_fan_step_curve_hysteresis.sv */
// ----------------------------------------------------------------------------
// dual_fan_step_curve_hysteresis
// CPU/GPU step-curve fan controller with downward hysteresis.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    temperature samples, one pair
//   m_*       out   m_tvalid / m_tready    fan speeds, only on change
//   APB       in    psel/penable/pready    curves, counts, hysteresis
//
// One request per cycle: sample register, one pass of lookup and hysteresis,
// result register. Fan state is updated as a request leaves the sample
// register, so back-to-back requests see each other's state. A stalled
// result holds the sample register only when that sample would emit.
// Reset clears fan state and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module dual_fan_step_curve_hysteresis #(
    parameter int CURVE_POINTS = dfsc_pkg::CURVE_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] cpu_sample_ok, [8:1] cpu_degrees, [9] gpu_sample_ok, [17:10] gpu_degrees
    input  logic [23:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] cpu_fan_speed, [15:8] gpu_fan_speed
    output logic [15:0]                     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dfsc_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [dfsc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dfsc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import dfsc_pkg::*;

    localparam int CW = 16 * CURVE_POINTS;

    logic [7:0]  hyst_reg;
    logic [3:0]  cpu_cnt_reg;
    logic [3:0]  gpu_cnt_reg;
    logic [63:0] cpu_lo_reg;
    logic [63:0] cpu_hi_reg;
    logic [63:0] gpu_lo_reg;
    logic [63:0] gpu_hi_reg;

    logic        in_vld_reg;
    logic [17:0] in_data_reg;
    logic        out_vld_reg;
    logic [15:0] out_data_reg;

    logic [7:0]  cpu_fan_reg;
    logic [7:0]  gpu_fan_reg;
    logic [7:0]  cpu_set_reg;
    logic [7:0]  gpu_set_reg;

    logic [7:0]  cpu_fan_next;
    logic [7:0]  gpu_fan_next;

    chan_res_t   cpu_res;
    chan_res_t   gpu_res;
    logic [127:0] cpu_curve_all;
    logic [127:0] gpu_curve_all;

    logic        emit;
    logic        advance;
    logic        wr_en;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg    <= HYST_RESET;
            cpu_cnt_reg <= '0;
            gpu_cnt_reg <= '0;
            cpu_lo_reg  <= '0;
            cpu_hi_reg  <= '0;
            gpu_lo_reg  <= '0;
            gpu_hi_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_HYST:      hyst_reg    <= pwdata[7:0];
                REG_CPU_COUNT: cpu_cnt_reg <= pwdata[3:0];
                REG_GPU_COUNT: gpu_cnt_reg <= pwdata[3:0];
                REG_CPU_LOW:   cpu_lo_reg  <= pwdata;
                REG_CPU_HIGH:  cpu_hi_reg  <= pwdata;
                REG_GPU_LOW:   gpu_lo_reg  <= pwdata;
                REG_GPU_HIGH:  gpu_hi_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_HYST:      prdata = {56'd0, hyst_reg};
            REG_CPU_COUNT: prdata = {60'd0, cpu_cnt_reg};
            REG_GPU_COUNT: prdata = {60'd0, gpu_cnt_reg};
            REG_CPU_LOW:   prdata = cpu_lo_reg;
            REG_CPU_HIGH:  prdata = cpu_hi_reg;
            REG_GPU_LOW:   prdata = gpu_lo_reg;
            REG_GPU_HIGH:  prdata = gpu_hi_reg;
            default:       prdata = '0;
        endcase
    end

    assign cpu_curve_all = {cpu_hi_reg, cpu_lo_reg};
    assign gpu_curve_all = {gpu_hi_reg, gpu_lo_reg};

    dfsc_chan #(.POINTS(CURVE_POINTS)) u_cpu (
        .sample_ok (in_data_reg[0]),
        .temp      (in_data_reg[8:1]),
        .curve     (cpu_curve_all[CW-1:0]),
        .count     (cpu_cnt_reg),
        .hyst_deg  (hyst_reg),
        .fan_now   (cpu_fan_reg),
        .set_temp  (cpu_set_reg),
        .res       (cpu_res)
    );

    dfsc_chan #(.POINTS(CURVE_POINTS)) u_gpu (
        .sample_ok (in_data_reg[9]),
        .temp      (in_data_reg[17:10]),
        .curve     (gpu_curve_all[CW-1:0]),
        .count     (gpu_cnt_reg),
        .hyst_deg  (hyst_reg),
        .fan_now   (gpu_fan_reg),
        .set_temp  (gpu_set_reg),
        .res       (gpu_res)
    );

    assign emit = (cpu_res.target != cpu_fan_reg) || (gpu_res.target != gpu_fan_reg);

    always_comb
    begin
        cpu_fan_next = cpu_res.target;
        gpu_fan_next = gpu_res.target;
        if (emit && ((cpu_res.target == HANDS_OFF) || (gpu_res.target == HANDS_OFF)))
        begin
            cpu_fan_next = HANDS_OFF;
            gpu_fan_next = HANDS_OFF;
        end
    end

    assign advance  = in_vld_reg && (!emit || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cpu_fan_reg <= '0;
            gpu_fan_reg <= '0;
            cpu_set_reg <= '0;
            gpu_set_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                cpu_fan_reg <= cpu_fan_next;
                gpu_fan_reg <= gpu_fan_next;
                cpu_set_reg <= cpu_res.set_temp;
                gpu_set_reg <= gpu_res.set_temp;
            end
            if (advance && emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[17:0];
        end
        if (advance && emit)
        begin
            out_data_reg <= {gpu_fan_next, cpu_fan_next};
        end
    end

endmodule
